### rtl/cbm_pkg.sv
package cbm_pkg;

   // transaction kinds on the request channel
   localparam logic [1:0] OP_READ    = 2'd0;
   localparam logic [1:0] OP_WRITE   = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   // mapper kinds
   localparam logic [2:0] KIND_NONE  = 3'd0;
   localparam logic [2:0] KIND_MMC1  = 3'd1;
   localparam logic [2:0] KIND_UXROM = 3'd2;
   localparam logic [2:0] KIND_CNROM = 3'd3;
   localparam logic [2:0] KIND_AXROM = 3'd4;

   // configuration register indexes
   localparam logic [1:0] CSR_MAPPER_KIND = 2'd0;
   localparam logic [1:0] CSR_PRG_COUNT   = 2'd1;
   localparam logic [1:0] CSR_CHR_COUNT   = 2'd2;
   localparam logic [1:0] CSR_VMIRROR     = 2'd3;

   // mirroring codes
   localparam logic [1:0] MIRROR_SINGLE0    = 2'd0;
   localparam logic [1:0] MIRROR_SINGLE1    = 2'd1;
   localparam logic [1:0] MIRROR_VERTICAL   = 2'd2;
   localparam logic [1:0] MIRROR_HORIZONTAL = 2'd3;

   // MMC1 serial port register selects
   localparam logic [1:0] SEL_CONTROL = 2'd0;
   localparam logic [1:0] SEL_CHR0    = 2'd1;
   localparam logic [1:0] SEL_CHR1    = 2'd2;
   localparam logic [1:0] SEL_PRG     = 2'd3;

   // MMC1 program bank modes
   localparam logic [1:0] PRG_MODE_FIX_LO = 2'd2;
   localparam logic [1:0] PRG_MODE_FIX_HI = 2'd3;

   localparam logic [2:0] SERIAL_WRITES = 3'd5;

   localparam logic [2:0] RESET_KIND      = KIND_NONE;
   localparam logic [7:0] RESET_PRG_COUNT = 8'd2;
   localparam logic [7:0] RESET_CHR_COUNT = 8'd1;
   localparam logic       RESET_VMIRROR   = 1'b0;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] prg_count;
      logic [7:0] chr_count;
      logic       vmirror;
   } cfg_type;

   typedef struct packed {
      logic [7:0] prg_lo;
      logic [7:0] prg_hi;
      logic [7:0] chr_lo;
      logic [7:0] chr_hi;
      logic [1:0] mirror;
      logic [2:0] ser_count;
      logic [4:0] ser_data;
      logic [4:0] ser_ctrl;
      logic [4:0] ser_chr0;
      logic [4:0] ser_chr1;
      logic [4:0] ser_prg;
   } map_state_type;

   typedef struct packed {
      logic [1:0]  mirror;
      logic [7:0]  chr_high;
      logic [7:0]  chr_low;
      logic [21:0] rom_offset;
   } rsp_data_type;

   localparam cfg_type RESET_CFG = '{
      kind:      RESET_KIND,
      prg_count: RESET_PRG_COUNT,
      chr_count: RESET_CHR_COUNT,
      vmirror:   RESET_VMIRROR
   };

   // header defaults, loaded at reset and on restart
   function automatic map_state_type header_defaults(input cfg_type cfg);
      map_state_type st;
      logic [7:0]    cc;
      cc           = (cfg.chr_count == 8'd0) ? 8'd1 : cfg.chr_count;
      st           = '0;
      st.prg_hi    = cfg.prg_count - 8'd1;
      st.chr_hi    = {cc[6:0], 1'b0} - 8'd1;
      st.mirror    = MIRROR_HORIZONTAL - {1'b0, cfg.vmirror};
      st.ser_count = SERIAL_WRITES;
      return st;
   endfunction

endpackage

### rtl/cartridge_bank_mapper.sv
// Cartridge bank mapper for the upper 32K CPU program window.
//
// Request channel (req_*): one transaction per CPU access. req_tuser carries
// the access kind (read, write, restart); req_tdata carries the window offset
// and the written byte. Every accepted transaction yields exactly one
// response on rsp_*: the program ROM byte offset, both 4K character banks
// and the mirroring mode, all taken after the access has been applied.
//
// An accepted transaction's response enters the output register, or the skid
// register while a response waits there; one transaction per cycle is taken
// while req_tready is high. The bank update is short logic on the bank registers.
// A two-entry response buffer (output register plus skid register) lets a
// request be taken while a response waits; req_tready drops only once both
// entries are full, and rises again the cycle after rsp_tready takes one.
//
// The csr_* port writes the header registers and is always ready; write it
// only while no response is outstanding. Synchronous reset loads the header
// register reset values, the derived bank defaults, and empties the buffer.
module cartridge_bank_mapper
   import cbm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // [14:0] window_offset, [22:15] write_data, [23] zero
   input  logic [1:0]  req_tuser,  // [1:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [21:0] rom_offset, [29:22] char_bank_low, [37:30] char_bank_high, [39:38] mirroring
   output logic [39:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   cfg_type       cfg_ff;
   map_state_type st_ff, st_in;
   rsp_data_type  result_in, out_ff, skid_ff;
   logic          out_valid_ff, skid_valid_ff;
   logic          req_accept, rsp_take;
   logic [1:0]    op;
   logic [14:0]   win_off;
   logic [7:0]    wr_data;
   logic [7:0]    bank;

   assign op      = req_tuser;
   assign win_off = req_tdata[14:0];
   assign wr_data = req_tdata[22:15];

   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_take   = out_valid_ff && rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;
   assign csr_ready  = 1'b1;

   // next bank state for the incoming transaction
   always_comb begin
      logic [1:0] prg_mode;
      logic [3:0] p;
      logic [7:0] ax_bank;
      logic [7:0] cn_bank;
      st_in    = st_ff;
      prg_mode = '0;
      p        = '0;
      ax_bank  = {4'd0, wr_data[2:0], 1'b0};
      cn_bank  = {5'd0, wr_data[1:0], 1'b0};
      if (op == OP_RESTART) begin
         st_in = header_defaults(cfg_ff);
      end else if (op == OP_WRITE) begin
         case (cfg_ff.kind)
            KIND_AXROM: begin
               st_in.prg_lo = ax_bank;
               st_in.prg_hi = ax_bank | 8'd1;
               st_in.mirror = wr_data[4] ? MIRROR_SINGLE0 : MIRROR_SINGLE1;
            end
            KIND_CNROM: begin
               st_in.chr_lo = cn_bank;
               st_in.chr_hi = cn_bank | 8'd1;
            end
            KIND_UXROM: begin
               st_in.prg_lo = {3'd0, wr_data[4:0]};
            end
            KIND_MMC1: begin
               if (wr_data[7]) begin
                  // clear the shift port and force fixed-high program mode
                  st_in.ser_count = SERIAL_WRITES;
                  st_in.ser_data  = '0;
                  st_in.ser_ctrl  = st_ff.ser_ctrl | 5'b01100;
               end else begin
                  st_in.ser_data  = {wr_data[0], st_ff.ser_data[4:1]};
                  st_in.ser_count = st_ff.ser_count - 3'd1;
                  if (st_in.ser_count == 3'd0) begin
                     st_in.ser_count = SERIAL_WRITES;
                     unique case (win_off[14:13])
                        SEL_CONTROL: begin
                           st_in.ser_ctrl = st_in.ser_data;
                           st_in.mirror   = st_in.ser_data[1:0];
                        end
                        SEL_CHR0: st_in.ser_chr0 = st_in.ser_data;
                        SEL_CHR1: st_in.ser_chr1 = st_in.ser_data;
                        SEL_PRG:  st_in.ser_prg  = st_in.ser_data;
                     endcase
                     if (st_in.ser_ctrl[4]) begin
                        st_in.chr_lo = {3'd0, st_in.ser_chr0};
                        st_in.chr_hi = {3'd0, st_in.ser_chr1};
                     end else begin
                        st_in.chr_lo = {3'd0, st_in.ser_chr0[4:1], 1'b0};
                        st_in.chr_hi = {3'd0, st_in.ser_chr0[4:1], 1'b1};
                     end
                     // bit 4 of the program register is the RAM enable
                     prg_mode = st_in.ser_ctrl[3:2];
                     p        = st_in.ser_prg[3:0];
                     case (prg_mode)
                        PRG_MODE_FIX_LO: begin
                           st_in.prg_lo = 8'd0;
                           st_in.prg_hi = {4'd0, p};
                        end
                        PRG_MODE_FIX_HI: begin
                           st_in.prg_lo = {4'd0, p};
                           st_in.prg_hi = cfg_ff.prg_count - 8'd1;
                        end
                        default: begin
                           st_in.prg_lo = {4'd0, p[3:1], 1'b0};
                           st_in.prg_hi = {4'd0, p[3:1], 1'b1};
                        end
                     endcase
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      bank                 = win_off[14] ? st_in.prg_hi : st_in.prg_lo;
      result_in.rom_offset = {bank, win_off[13:0]};
      result_in.chr_low    = st_in.chr_lo;
      result_in.chr_high   = st_in.chr_hi;
      result_in.mirror     = st_in.mirror;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= RESET_CFG;
         st_ff         <= header_defaults(RESET_CFG);
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_MAPPER_KIND: cfg_ff.kind      <= csr_data[2:0];
               CSR_PRG_COUNT:   cfg_ff.prg_count <= csr_data;
               CSR_CHR_COUNT:   cfg_ff.chr_count <= csr_data;
               CSR_VMIRROR:     cfg_ff.vmirror   <= csr_data[0];
            endcase
         end
         if (req_accept) begin
            st_ff <= st_in;
         end
         if (skid_valid_ff) begin
            // drain the skid entry into the output register
            if (rsp_take) begin
               out_ff        <= skid_ff;
               skid_valid_ff <= 1'b0;
            end
         end else if (req_accept) begin
            if (!out_valid_ff || rsp_take) begin
               out_ff       <= result_in;
               out_valid_ff <= 1'b1;
            end else begin
               skid_ff       <= result_in;
               skid_valid_ff <= 1'b1;
            end
         end else if (rsp_take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

endmodule

### rtl/cbm_checker.sv
module cbm_checker
   import cbm_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // reset empties the response buffer
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("response buffer not empty after reset");

   // back-pressure only once the output register is occupied
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request stalled with no response pending");

   // an accepted request with a free output slot is shown next cycle
   a_rsp_next: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (!rsp_tvalid || rsp_tready) |=> rsp_tvalid)
      else $error("response missing one cycle after acceptance");

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (.*);

### test/cartridge_bank_mapper_test.sv
`timescale 1ns / 1ps

module cartridge_bank_mapper_test;
   import cbm_pkg::*;

   // the request encoding leaves one operation code spare; it behaves as a read
   localparam logic [1:0] OP_SPARE    = 2'd3;
   localparam logic [2:0] KIND_UNUSED = 3'd7;
   localparam int         QUIET_LIMIT = 2000;

   typedef struct packed {
      logic [1:0]  op;
      logic [14:0] offset;
      logic [7:0]  data;
   } cpu_access_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;  // [14:0] window_offset, [22:15] write_data, [23] zero
   logic [1:0]  req_tuser = '0;  // [1:0] operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [21:0] rom_offset, [29:22] char_bank_low, [37:30] char_bank_high, [39:38] mirroring
   logic [39:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   cartridge_bank_mapper u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // header registers as the block should hold them
   logic [2:0] cfg_kind      = RESET_KIND;
   logic [7:0] cfg_prg_count = RESET_PRG_COUNT;
   logic [7:0] cfg_chr_count = RESET_CHR_COUNT;
   logic       cfg_vmirror   = RESET_VMIRROR;

   // bank state
   logic [7:0] prg_lo, prg_hi, chr_lo, chr_hi;
   logic [1:0] mirror;
   logic [2:0] shift_count;
   logic [4:0] shift_reg, mmc_ctrl, mmc_chr0, mmc_chr1, mmc_prg;

   cpu_access_type pending_accesses[$];
   rsp_data_type   expected_views[$];
   cpu_access_type offered;
   int unsigned    send_gap = 0;
   int unsigned    stall_left = 0;
   int unsigned    quiet_cycles = 0;
   int unsigned    mismatches = 0;
   bit             send_idle_on = 1'b1;
   bit             rsp_idle_on = 1'b1;
   bit             hold_off_req = 1'b0;

   function automatic void load_header_defaults();
      logic [7:0] cc;
      cc          = (cfg_chr_count == 8'd0) ? 8'd1 : cfg_chr_count;
      prg_lo      = 8'd0;
      prg_hi      = cfg_prg_count - 8'd1;
      chr_lo      = 8'd0;
      chr_hi      = (cc << 1) - 8'd1;
      mirror      = cfg_vmirror ? MIRROR_VERTICAL : MIRROR_HORIZONTAL;
      shift_count = SERIAL_WRITES;
      shift_reg   = '0;
      mmc_ctrl    = '0;
      mmc_chr0    = '0;
      mmc_chr1    = '0;
      mmc_prg     = '0;
   endfunction

   function automatic void mmc1_serial_write(input logic [14:0] off, input logic [7:0] d);
      logic [3:0] p;
      if (d[7]) begin
         shift_count = SERIAL_WRITES;
         shift_reg   = '0;
         mmc_ctrl    = mmc_ctrl | 5'b01100;
         return;
      end
      shift_reg   = {d[0], shift_reg[4:1]};
      shift_count = shift_count - 3'd1;
      if (shift_count != 3'd0)
         return;
      shift_count = SERIAL_WRITES;
      case (off[14:13])
         SEL_CONTROL: begin
            mmc_ctrl = shift_reg;
            mirror   = shift_reg[1:0];
         end
         SEL_CHR0: mmc_chr0 = shift_reg;
         SEL_CHR1: mmc_chr1 = shift_reg;
         default:  mmc_prg  = shift_reg;
      endcase
      if (mmc_ctrl[4]) begin
         chr_lo = {3'b000, mmc_chr0};
         chr_hi = {3'b000, mmc_chr1};
      end else begin
         chr_lo = {3'b000, mmc_chr0[4:1], 1'b0};
         chr_hi = {3'b000, mmc_chr0[4:1], 1'b1};
      end
      // bit 4 of the program register enables program RAM, not a bank bit
      p = mmc_prg[3:0];
      case (mmc_ctrl[3:2])
         PRG_MODE_FIX_LO: begin
            prg_lo = 8'd0;
            prg_hi = {4'b0000, p};
         end
         PRG_MODE_FIX_HI: begin
            prg_lo = {4'b0000, p};
            prg_hi = cfg_prg_count - 8'd1;
         end
         default: begin
            prg_lo = {4'b0000, p[3:1], 1'b0};
            prg_hi = {4'b0000, p[3:1], 1'b1};
         end
      endcase
   endfunction

   // apply one CPU access and return the bank view seen after it
   function automatic rsp_data_type map_access(input cpu_access_type a);
      rsp_data_type v;
      logic [7:0]   bank;
      if (a.op == OP_RESTART) begin
         load_header_defaults();
      end else if (a.op == OP_WRITE) begin
         case (cfg_kind)
            KIND_AXROM: begin
               prg_lo = {4'b0000, a.data[2:0], 1'b0};
               prg_hi = prg_lo + 8'd1;
               mirror = a.data[4] ? MIRROR_SINGLE0 : MIRROR_SINGLE1;
            end
            KIND_CNROM: begin
               chr_lo = {5'b00000, a.data[1:0], 1'b0};
               chr_hi = chr_lo + 8'd1;
            end
            KIND_UXROM: prg_lo = {3'b000, a.data[4:0]};
            KIND_MMC1:  mmc1_serial_write(a.offset, a.data);
            default: ;
         endcase
      end
      bank         = a.offset[14] ? prg_hi : prg_lo;
      v.rom_offset = {bank, a.offset[13:0]};
      v.chr_low    = chr_lo;
      v.chr_high   = chr_hi;
      v.mirror     = mirror;
      return v;
   endfunction

   function automatic int unsigned pick_gap(input bit enabled);
      int unsigned r;
      if (!enabled)
         return 0;
      r = $urandom_range(99);
      if (r < 65)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   function automatic cpu_access_type random_access();
      cpu_access_type a;
      int unsigned    r;
      r        = $urandom_range(99);
      a.offset = 15'($urandom_range(32767));
      a.data   = 8'($urandom_range(255));
      if (r < 4)
         a.op = OP_RESTART;
      else if (r < 8)
         a.op = OP_SPARE;
      else if (r < 55)
         a.op = OP_WRITE;
      else
         a.op = OP_READ;
      // keep most MMC1 writes as shift bits so that five-write sequences complete
      if (cfg_kind == KIND_MMC1 && $urandom_range(99) < 92)
         a.data[7] = 1'b0;
      r = $urandom_range(15);
      if (r == 0)
         a.offset = '0;
      else if (r == 1)
         a.offset = '1;
      return a;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_views.push_back(map_access(offered));
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_accesses.size() > 0) begin
               offered = pending_accesses.pop_front();
               req_tdata  <= {1'b0, offered.data, offered.offset};
               req_tuser  <= offered.op;
               req_tvalid <= 1'b1;
               send_gap = pick_gap(send_idle_on);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            stall_left = 64;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_idle_on && $urandom_range(99) < 25) begin
            stall_left = pick_gap(1'b1);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      rsp_data_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_views.size() == 0) begin
            $display("%0t: response with nothing expected, got %h", $time, rsp_tdata);
            mismatches++;
         end else begin
            want = expected_views.pop_front();
            if (got.rom_offset !== want.rom_offset) begin
               $display("%0t: rom_offset expected %h got %h", $time,
                        want.rom_offset, got.rom_offset);
               mismatches++;
            end
            if (got.chr_low !== want.chr_low) begin
               $display("%0t: char_bank_low expected %h got %h", $time,
                        want.chr_low, got.chr_low);
               mismatches++;
            end
            if (got.chr_high !== want.chr_high) begin
               $display("%0t: char_bank_high expected %h got %h", $time,
                        want.chr_high, got.chr_high);
               mismatches++;
            end
            if (got.mirror !== want.mirror) begin
               $display("%0t: mirroring expected %h got %h", $time,
                        want.mirror, got.mirror);
               mismatches++;
            end
         end
      end
   end

   // stop a hung run
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("cartridge_bank_mapper_test NOT OK");
            $finish;
         end
      end
   end

   function automatic void queue_access(input logic [1:0] op, input logic [14:0] off,
                                        input logic [7:0] d);
      cpu_access_type a;
      a.op     = op;
      a.offset = off;
      a.data   = d;
      pending_accesses.push_back(a);
   endfunction

   // wait until every transaction has been taken and answered; sample away from the
   // rising edge so the driver's offer for this cycle is already visible
   task automatic settle();
      do
         @(negedge clock);
      while (pending_accesses.size() != 0 || req_tvalid || expected_views.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [7:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MAPPER_KIND: cfg_kind      = val[2:0];
         CSR_PRG_COUNT:   cfg_prg_count = val;
         CSR_CHR_COUNT:   cfg_chr_count = val;
         default:         cfg_vmirror   = val[0];
      endcase
   endtask

   task automatic set_header(input logic [2:0] k, input logic [7:0] p, input logic [7:0] c,
                             input logic v);
      settle();
      write_csr(CSR_MAPPER_KIND, {5'b00000, k});
      write_csr(CSR_PRG_COUNT, p);
      write_csr(CSR_CHR_COUNT, c);
      write_csr(CSR_VMIRROR, {7'b0000000, v});
   endtask

   task automatic random_phase(input logic [2:0] k, input logic [7:0] p, input logic [7:0] c,
                               input logic v, input bit send_idle, input bit recv_idle,
                               input bit hold);
      set_header(k, p, c, v);
      send_idle_on = send_idle;
      rsp_idle_on  = recv_idle;
      queue_access(OP_RESTART, 15'($urandom_range(32767)), 8'($urandom_range(255)));
      repeat (150) pending_accesses.push_back(random_access());
      // hold the response side off while the sender keeps offering
      if (hold)
         hold_off_req = 1'b1;
      settle();
   endtask

   initial begin
      load_header_defaults();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // header reset values, no banking: writes leave the banks alone
      queue_access(OP_READ, 15'h0000, 8'h00);
      queue_access(OP_READ, 15'h7fff, 8'hff);
      queue_access(OP_SPARE, 15'h4000, 8'h5a);
      queue_access(OP_WRITE, 15'h3fff, 8'hff);

      set_header(KIND_AXROM, 8'd255, 8'd255, 1'b1);
      queue_access(OP_RESTART, 15'h0000, 8'h00);
      queue_access(OP_WRITE, 15'h7fff, 8'hff);
      queue_access(OP_WRITE, 15'h0000, 8'h08);

      set_header(KIND_CNROM, 8'd1, 8'd0, 1'b0);
      queue_access(OP_RESTART, 15'h4000, 8'h00);
      queue_access(OP_WRITE, 15'h7fff, 8'hff);
      queue_access(OP_WRITE, 15'h0000, 8'h00);

      // zero program bank count: the fixed upper bank wraps round
      set_header(KIND_UXROM, 8'd0, 8'd2, 1'b1);
      queue_access(OP_RESTART, 15'h0000, 8'h00);
      queue_access(OP_READ, 15'h4000, 8'h00);
      queue_access(OP_WRITE, 15'h0000, 8'hff);

      // MMC1: clear the shift port, then five writes into the program register
      set_header(KIND_MMC1, 8'd255, 8'd0, 1'b1);
      queue_access(OP_RESTART, 15'h0000, 8'h00);
      queue_access(OP_WRITE, 15'h0000, 8'h80);
      repeat (5) queue_access(OP_WRITE, 15'h7fff, 8'h7f);
      queue_access(OP_READ, 15'h4000, 8'h00);
      queue_access(OP_READ, 15'h3fff, 8'h00);

      random_phase(KIND_MMC1, 8'd16, 8'd0, 1'b0, 1'b1, 1'b1, 1'b0);
      random_phase(KIND_MMC1, 8'd255, 8'd255, 1'b1, 1'b0, 1'b0, 1'b1);
      random_phase(KIND_MMC1, 8'd1, 8'd3, 1'b0, 1'b1, 1'b0, 1'b0);
      random_phase(KIND_UXROM, 8'd8, 8'd0, 1'b1, 1'b0, 1'b1, 1'b0);
      random_phase(KIND_UXROM, 8'd0, 8'd1, 1'b0, 1'b1, 1'b1, 1'b0);
      random_phase(KIND_CNROM, 8'd2, 8'd4, 1'b1, 1'b1, 1'b1, 1'b0);
      random_phase(KIND_CNROM, 8'd1, 8'd128, 1'b0, 1'b0, 1'b0, 1'b0);
      random_phase(KIND_AXROM, 8'd8, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1);
      random_phase(KIND_AXROM, 8'd255, 8'd255, 1'b0, 1'b1, 1'b0, 1'b0);
      random_phase(KIND_NONE, 8'd2, 8'd1, 1'b1, 1'b1, 1'b1, 1'b0);
      random_phase(KIND_UNUSED, 8'd200, 8'd17, 1'b0, 1'b1, 1'b1, 1'b0);
      random_phase(KIND_MMC1, 8'($urandom_range(1, 255)), 8'($urandom_range(255)),
                   1'($urandom_range(1)), 1'b1, 1'b1, 1'b0);

      settle();
      if (mismatches == 0)
         $display("cartridge_bank_mapper_test OK");
      else
         $display("cartridge_bank_mapper_test NOT OK");
      $finish;
   end

endmodule
